// ----- rtl/cfsp_pkg.sv -----
`timescale 1ns / 1ps

package cfsp_pkg;

	localparam int CORDIC_STEPS_DEF = 24;
	localparam int CFG_IDX_W = 8;
	localparam int TBL_DEPTH = 33;
	localparam int TIDX_W = 6;

	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_AMPLITUDE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP       = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START     = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_STOP      = 8'd3;

	localparam logic [63:0] ONE62 = 64'h4000_0000_0000_0000;

	typedef logic [63:0] tbl_t [TBL_DEPTH];

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_ANG,
		OP_EXP,
		OP_REDUCE,
		OP_ITER,
		OP_QUAD,
		OP_MRH,
		OP_MRL,
		OP_MRW,
		OP_MIH,
		OP_MIL,
		OP_MIW,
		OP_EMIT,
		OP_TRR,
		OP_TRI,
		OP_TRW,
		OP_TIR,
		OP_TII,
		OP_TIW
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [TIDX_W-1:0] step;
	} cmd_t;

	typedef struct packed {
		logic reduced;
		logic out_busy;
		logic iface;
	} sts_t;

	// shift-subtract unsigned division, only used to build table and gain constants
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], n[i]};
			if (rem >= {1'b0, d}) begin
				rem = rem - {1'b0, d};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// sum of +/- (2^-sm) * (2^-ss)^j / (1 + j*dinc), Q.62
	function automatic logic [63:0] series(input int sm, input int ss, input int dinc,
			input bit alt);
		logic [63:0] p;
		logic [63:0] d;
		logic [63:0] s;
		logic [63:0] t;
		bit neg;
		p = ONE62 >> sm;
		d = 64'd1;
		s = 64'd0;
		neg = 1'b0;
		while (p != 64'd0) begin
			t = udiv64(p, d);
			if (neg) s = s - t;
			else s = s + t;
			if (alt) neg = !neg;
			p = p >> ss;
			d = d + 64'(dinc);
		end
		return s;
	endfunction

	// atan(1/3) series, Q.62
	function automatic logic [63:0] series_third();
		logic [63:0] p;
		logic [63:0] d;
		logic [63:0] s;
		logic [63:0] t;
		bit neg;
		p = udiv64(ONE62, 64'd3);
		d = 64'd1;
		s = 64'd0;
		neg = 1'b0;
		while (p != 64'd0) begin
			t = udiv64(p, d);
			if (neg) s = s - t;
			else s = s + t;
			neg = !neg;
			p = udiv64(p, 64'd9);
			d = d + 64'd2;
		end
		return s;
	endfunction

	function automatic tbl_t build_atan();
		tbl_t r;
		r[0] = (series(1, 2, 2, 1'b1) + series_third()) >> 6;
		for (int i = 1; i < TBL_DEPTH; i++) r[i] = series(i, 2 * i, 2, 1'b1) >> 6;
		return r;
	endfunction

	function automatic tbl_t build_ln();
		tbl_t r;
		r[0] = series(1, 1, 1, 1'b0) >> 6;
		for (int i = 1; i < TBL_DEPTH; i++) r[i] = series(i, i, 1, 1'b1) >> 6;
		return r;
	endfunction

	// CORDIC gain as a logarithm, Q.56
	function automatic logic [63:0] gain56(input int n);
		logic [63:0] g;
		g = 64'd0;
		for (int i = 0; i < n; i++) begin
			if (i == 0) g = g + series(1, 1, 1, 1'b0);
			else g = g + series(2 * i, 2 * i, 1, 1'b1);
		end
		return g >> 7;
	endfunction

	localparam tbl_t ATAN_TBL = build_atan();
	localparam tbl_t LN_TBL = build_ln();

endpackage

// ----- rtl/cfsp_ctrl.sv -----
`timescale 1ns / 1ps

module cfsp_ctrl
	import cfsp_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output cmd_t cmd,
	input  sts_t sts
);

	localparam int CW = $clog2(CORDIC_STEPS);
	localparam logic [CW-1:0] LAST = CW'(CORDIC_STEPS - 1);

	typedef enum logic [4:0] {
		S_IDLE, S_ANG, S_EXP, S_RED, S_ITER, S_QUAD,
		S_MRH, S_MRL, S_MRW, S_MIH, S_MIL, S_MIW, S_EMIT,
		S_TRR, S_TRI, S_TRW, S_TIR, S_TII, S_TIW
	} state_t;

	state_t state_q;
	logic [CW-1:0] cnt_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd.step = TIDX_W'(cnt_q);
		unique case (state_q)
			S_IDLE: cmd.op = in_valid ? OP_LOAD : OP_NONE;
			S_ANG:  cmd.op = OP_ANG;
			S_EXP:  cmd.op = OP_EXP;
			S_RED:  cmd.op = sts.reduced ? OP_NONE : OP_REDUCE;
			S_ITER: cmd.op = OP_ITER;
			S_QUAD: cmd.op = OP_QUAD;
			S_MRH:  cmd.op = OP_MRH;
			S_MRL:  cmd.op = OP_MRL;
			S_MRW:  cmd.op = OP_MRW;
			S_MIH:  cmd.op = OP_MIH;
			S_MIL:  cmd.op = OP_MIL;
			S_MIW:  cmd.op = OP_MIW;
			S_EMIT: cmd.op = sts.out_busy ? OP_NONE : OP_EMIT;
			S_TRR:  cmd.op = OP_TRR;
			S_TRI:  cmd.op = OP_TRI;
			S_TRW:  cmd.op = OP_TRW;
			S_TIR:  cmd.op = OP_TIR;
			S_TII:  cmd.op = OP_TII;
			S_TIW:  cmd.op = OP_TIW;
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_ANG;
				S_ANG:  state_q <= S_EXP;
				S_EXP:  state_q <= S_RED;
				S_RED: begin
					if (sts.reduced) begin
						state_q <= S_ITER;
						cnt_q <= '0;
					end
				end
				S_ITER: begin
					if (cnt_q == LAST) state_q <= S_QUAD;
					else cnt_q <= cnt_q + 1'b1;
				end
				S_QUAD: state_q <= S_MRH;
				S_MRH:  state_q <= S_MRL;
				S_MRL:  state_q <= S_MRW;
				S_MRW:  state_q <= S_MIH;
				S_MIH:  state_q <= S_MIL;
				S_MIL:  state_q <= S_MIW;
				S_MIW:  state_q <= S_EMIT;
				S_EMIT: if (!sts.out_busy) state_q <= sts.iface ? S_TRR : S_IDLE;
				S_TRR:  state_q <= S_TRI;
				S_TRI:  state_q <= S_TRW;
				S_TRW:  state_q <= S_TIR;
				S_TIR:  state_q <= S_TII;
				S_TII:  state_q <= S_TIW;
				S_TIW:  state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/cfsp_dp.sv -----
`timescale 1ns / 1ps

module cfsp_dp
	import cfsp_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]           cfg_data,
	input  logic                  first_slice,
	input  logic [31:0]           position,
	input  logic signed [15:0]    index_real,
	input  logic signed [15:0]    index_imag,
	input  logic signed [15:0]    trans_real,
	input  logic signed [15:0]    trans_imag,
	input  logic                  interface_here,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [31:0]    field_real_out,
	output logic signed [31:0]    field_imag_out,
	input  cmd_t                  cmd,
	output sts_t                  sts
);

	localparam logic [63:0] GAIN = gain56(CORDIC_STEPS);
	localparam logic signed [61:0] PI4 = $signed({4'b0, ATAN_TBL[0][57:0]});
	localparam logic signed [61:0] PI2 = PI4 <<< 1;
	localparam logic signed [61:0] LN2 = $signed({4'b0, LN_TBL[0][57:0]});
	localparam logic signed [61:0] GAIN_S = $signed({4'b0, GAIN[57:0]});

	// configuration
	logic [30:0] amp_q;
	logic [31:0] phase_q, win_start_q, win_stop_q;

	// field state and output beat
	logic signed [31:0] fre_q, fim_q;
	logic out_valid_q;
	logic signed [31:0] out_re_q, out_im_q;

	// per-item payload
	logic signed [15:0] nr_q, ni_q, tr_q, ti_q;
	logic iface_q;
	logic signed [61:0] ang_q, e_q;
	logic [1:0] q_q;
	logic signed [5:0] qe_q;
	logic signed [51:0] x_q, y_q;
	logic [61:0] yq_q;
	logic signed [39:0] rx_q, ry_q;
	logic [26:0] ex_q;
	logic [5:0] sh_q;
	logic signed [67:0] acc_q;
	logic signed [31:0] tmp_q;

	logic in_window;
	logic signed [32:0] ma;
	logic signed [27:0] mb;
	logic signed [60:0] prod;
	logic [5:0] sh_sel;
	logic signed [67:0] rnd_sum, rnd_res;
	logic signed [31:0] sat_res;
	logic ang_ok, e_ok;
	logic [TIDX_W-1:0] ln_idx;
	logic signed [61:0] atan_v, ln_v;
	logic signed [51:0] dx, dy, xr, yr, xrs, yrs;
	logic signed [6:0] shv;

	function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
		if (v > 68'sd2147483647) return 32'sh7FFF_FFFF;
		if (v < -68'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	assign in_window = (position > win_start_q) && (position < win_stop_q);

	// shared multiplier
	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.op)
			OP_ANG: begin
				ma = $signed({1'b0, phase_q});
				mb = 28'(nr_q);
			end
			OP_EXP: begin
				ma = $signed({1'b0, phase_q});
				mb = 28'(ni_q);
			end
			OP_MRH: begin
				ma = 33'($signed(rx_q[39:19]));
				mb = $signed({1'b0, ex_q});
			end
			OP_MRL: begin
				ma = $signed({14'b0, rx_q[18:0]});
				mb = $signed({1'b0, ex_q});
			end
			OP_MIH: begin
				ma = 33'($signed(ry_q[39:19]));
				mb = $signed({1'b0, ex_q});
			end
			OP_MIL: begin
				ma = $signed({14'b0, ry_q[18:0]});
				mb = $signed({1'b0, ex_q});
			end
			OP_TRR: begin
				ma = 33'(fre_q);
				mb = 28'(tr_q);
			end
			OP_TRI: begin
				ma = 33'(fim_q);
				mb = 28'(ti_q);
			end
			OP_TIR: begin
				ma = 33'(fre_q);
				mb = 28'(ti_q);
			end
			OP_TII: begin
				ma = 33'(fim_q);
				mb = 28'(tr_q);
			end
			default: ;
		endcase
	end

	assign prod = ma * mb;

	// round half up, arithmetic shift, saturate
	assign sh_sel = (cmd.op == OP_TRW || cmd.op == OP_TIW) ? 6'd14 : sh_q;
	assign rnd_sum = acc_q + (68'sd1 <<< (sh_sel - 6'd1));
	assign rnd_res = rnd_sum >>> sh_sel;
	assign sat_res = sat32(rnd_res);

	assign ang_ok = (ang_q <= PI4) && (ang_q >= -PI4);
	assign e_ok = (e_q >= 62'sd0) && (e_q < LN2);

	assign ln_idx = cmd.step + 1'b1;
	assign atan_v = $signed({4'b0, ATAN_TBL[cmd.step][57:0]});
	assign ln_v = $signed({4'b0, LN_TBL[ln_idx][57:0]});
	assign dx = y_q >>> cmd.step;
	assign dy = x_q >>> cmd.step;

	// quarter turns applied exactly
	always_comb begin
		case (q_q)
			2'd1: begin
				xr = -y_q;
				yr = x_q;
			end
			2'd2: begin
				xr = -x_q;
				yr = -y_q;
			end
			2'd3: begin
				xr = y_q;
				yr = -x_q;
			end
			default: begin
				xr = x_q;
				yr = y_q;
			end
		endcase
	end

	assign xrs = xr + 52'sd2048;
	assign yrs = yr + 52'sd2048;
	assign shv = 7'sd29 - 7'(qe_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_q <= '0;
			phase_q <= '0;
			win_start_q <= '0;
			win_stop_q <= '0;
			fre_q <= '0;
			fim_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_SOURCE_AMPLITUDE: amp_q <= cfg_data[30:0];
					REG_PHASE_STEP:       phase_q <= cfg_data;
					REG_WINDOW_START:     win_start_q <= cfg_data;
					REG_WINDOW_STOP:      win_stop_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.op == OP_LOAD && first_slice) begin
				fre_q <= $signed({1'b0, amp_q});
				fim_q <= '0;
			end
			if (cmd.op == OP_MRW) fre_q <= sat_res;
			if (cmd.op == OP_MIW) fim_q <= sat_res;
			if (cmd.op == OP_TIW) begin
				fre_q <= tmp_q;
				fim_q <= sat_res;
			end
			if (cmd.op == OP_EMIT) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				nr_q <= index_real;
				ni_q <= in_window ? 16'sd0 : index_imag;
				tr_q <= trans_real;
				ti_q <= trans_imag;
				iface_q <= interface_here;
			end
			OP_ANG: ang_q <= -(62'(prod) <<< 12);
			OP_EXP: begin
				e_q <= (62'(prod) <<< 12) - GAIN_S;
				x_q <= 52'(fre_q) <<< 16;
				y_q <= 52'(fim_q) <<< 16;
				yq_q <= 62'(1) << 60;
				q_q <= 2'd0;
				qe_q <= 6'sd0;
			end
			OP_REDUCE: begin
				if (ang_q > PI4) begin
					ang_q <= ang_q - PI2;
					q_q <= q_q + 2'd1;
				end else if (ang_q < -PI4) begin
					ang_q <= ang_q + PI2;
					q_q <= q_q - 2'd1;
				end
				if (e_q < 62'sd0) begin
					e_q <= e_q + LN2;
					qe_q <= qe_q - 6'sd1;
				end else if (e_q >= LN2) begin
					e_q <= e_q - LN2;
					qe_q <= qe_q + 6'sd1;
				end
			end
			OP_ITER: begin
				if (ang_q >= 62'sd0) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					ang_q <= ang_q - atan_v;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					ang_q <= ang_q + atan_v;
				end
				if (e_q >= ln_v) begin
					e_q <= e_q - ln_v;
					yq_q <= yq_q + (yq_q >> ln_idx);
				end
			end
			OP_QUAD: begin
				rx_q <= xrs[51:12];
				ry_q <= yrs[51:12];
				ex_q <= 27'((yq_q + (62'(1) << 34)) >> 35);
				if (shv < 7'sd1) sh_q <= 6'd1;
				else if (shv > 7'sd62) sh_q <= 6'd62;
				else sh_q <= shv[5:0];
			end
			OP_MRH, OP_MIH: acc_q <= 68'(prod) <<< 19;
			OP_MRL, OP_MIL, OP_TII: acc_q <= acc_q + 68'(prod);
			OP_TRI: acc_q <= acc_q - 68'(prod);
			OP_TRR, OP_TIR: acc_q <= 68'(prod);
			OP_TRW: tmp_q <= sat_res;
			OP_EMIT: begin
				out_re_q <= fre_q;
				out_im_q <= fim_q;
			end
			default: ;
		endcase
	end

	assign sts.reduced = ang_ok && e_ok;
	assign sts.out_busy = out_valid_q && !out_ready;
	assign sts.iface = iface_q;

	assign out_valid = out_valid_q;
	assign field_real_out = out_re_q;
	assign field_imag_out = out_im_q;

endmodule

// ----- rtl/complex_field_slice_propagator_top.sv -----
`timescale 1ns / 1ps
// Processing: after input accept the block forms the angle and exponent, range-reduces
// both, runs CORDIC_STEPS rotation steps, applies the quarter turns and rescales the field.
// The field is then emitted; when interface_here is set, the field state is then multiplied
// by the transmission. A new item is taken only once the previous one is done; all
// multiplies share one 33x28 multiplier. Output register frees the result side.
// Reset: arst_n clears configuration registers, field state and output valid to zero.
module complex_field_slice_propagator_top
	import cfsp_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 first_slice,
	input  logic [31:0]          position,
	input  logic signed [15:0]   index_real,
	input  logic signed [15:0]   index_imag,
	input  logic signed [15:0]   trans_real,
	input  logic signed [15:0]   trans_imag,
	input  logic                 interface_here,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [31:0]   field_real_out,
	output logic signed [31:0]   field_imag_out
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	cfsp_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	cfsp_dp #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.first_slice    (first_slice),
		.position       (position),
		.index_real     (index_real),
		.index_imag     (index_imag),
		.trans_real     (trans_real),
		.trans_imag     (trans_imag),
		.interface_here (interface_here),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.field_real_out (field_real_out),
		.field_imag_out (field_imag_out),
		.cmd            (cmd),
		.sts            (sts)
	);

endmodule

// ----- sim/field_slice_checker.sv -----
`timescale 1ns / 1ps

module field_slice_checker
	import cfsp_pkg::*;
#(
	parameter int STEPS = CORDIC_STEPS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic                 first_slice,
	input  logic [31:0]          position,
	input  logic signed [15:0]   index_real,
	input  logic signed [15:0]   index_imag,
	input  logic signed [15:0]   trans_real,
	input  logic signed [15:0]   trans_imag,
	input  logic                 interface_here,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic signed [31:0]   field_real_out,
	input  logic signed [31:0]   field_imag_out,
	output int                   pending,
	output int                   errors
);

	typedef struct {
		logic signed [31:0] re;
		logic signed [31:0] im;
	} field_t;

	localparam longint unsigned Q62_ONE = 64'h4000_0000_0000_0000;

	longint atan_q56 [32];
	longint ln_q56 [33];
	longint gain_q56;

	logic [30:0] src_amp;
	logic [31:0] phase_step;
	logic [31:0] win_lo;
	logic [31:0] win_hi;
	logic signed [31:0] fwd_re;
	logic signed [31:0] fwd_im;

	field_t expected_fields [$];

	function automatic longint unsigned power_series(longint unsigned m, longint unsigned step,
			longint unsigned dinc, bit alt);
		longint unsigned p, d, s, t;
		bit neg;
		p = Q62_ONE / m;
		d = 1;
		s = 0;
		neg = 1'b0;
		while (p != 0) begin
			t = p / d;
			if (neg) s = s - t;
			else s = s + t;
			if (alt) neg = !neg;
			p = p / step;
			d = d + dinc;
		end
		return s;
	endfunction

	function automatic longint round_half_up(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	initial begin
		longint unsigned g, m;
		atan_q56[0] = longint'((power_series(2, 4, 2, 1) + power_series(3, 9, 2, 1)) >> 6);
		for (int i = 1; i < 32; i++) begin
			m = 64'd1 << i;
			atan_q56[i] = longint'(power_series(m, m * m, 2, 1) >> 6);
		end
		ln_q56[0] = longint'(power_series(2, 2, 1, 0) >> 6);
		for (int i = 1; i < 33; i++) begin
			m = 64'd1 << i;
			ln_q56[i] = longint'(power_series(m, m, 1, 1) >> 6);
		end
		g = 0;
		for (int i = 0; i < STEPS; i++) begin
			if (i == 0) g = g + power_series(2, 2, 1, 0);
			else begin
				m = 64'd1 << (2 * i);
				g = g + power_series(m, m, 1, 1);
			end
		end
		gain_q56 = longint'(g >> 7);
	end

	// rotate and scale the forward field for one slice; updates the field state
	function automatic field_t propagate_slice();
		longint ang, e, x, y, t, dx, dy, rx, ry, ex, nr, ni, ps, pi4, ln2;
		longint unsigned yq;
		int q, qe, sh;
		field_t r;
		q = 0;
		qe = 0;
		pi4 = atan_q56[0];
		ln2 = ln_q56[0];
		ps = longint'(phase_step);
		nr = longint'(index_real);
		ni = longint'(index_imag);
		if (first_slice) begin
			fwd_re = $signed({1'b0, src_amp});
			fwd_im = 0;
		end
		if (position > win_lo && position < win_hi) ni = 0;
		ang = -(ps * nr * 4096);
		e = ps * ni * 4096 - gain_q56;
		while (ang > pi4) begin ang = ang - 2 * pi4; q++; end
		while (ang < -pi4) begin ang = ang + 2 * pi4; q--; end
		x = longint'(fwd_re) * 65536;
		y = longint'(fwd_im) * 65536;
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (ang >= 0) begin x = x - dx; y = y + dy; ang = ang - atan_q56[i]; end
			else begin x = x + dx; y = y - dy; ang = ang + atan_q56[i]; end
		end
		case (q & 3)
			1: begin t = x; x = -y; y = t; end
			2: begin x = -x; y = -y; end
			3: begin t = x; x = y; y = -t; end
			default: ;
		endcase
		rx = round_half_up(x, 12);
		ry = round_half_up(y, 12);
		while (e < 0) begin e = e + ln2; qe--; end
		while (e >= ln2) begin e = e - ln2; qe++; end
		yq = 64'd1 << 60;
		for (int i = 1; i <= STEPS; i++) begin
			if (e >= ln_q56[i]) begin
				e = e - ln_q56[i];
				yq = yq + (yq >> i);
			end
		end
		ex = longint'((yq + (64'd1 << 34)) >> 35);
		sh = 29 - qe;
		if (sh < 1) sh = 1;
		if (sh > 62) sh = 62;
		fwd_re = clamp32(round_half_up(rx * ex, sh));
		fwd_im = clamp32(round_half_up(ry * ex, sh));
		r.re = fwd_re;
		r.im = fwd_im;
		if (interface_here) begin
			rx = longint'(fwd_re);
			ry = longint'(fwd_im);
			fwd_re = clamp32(round_half_up(rx * trans_real - ry * trans_imag, 14));
			fwd_im = clamp32(round_half_up(rx * trans_imag + ry * trans_real, 14));
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		field_t got, want;
		if (!arst_n) begin
			src_amp <= '0;
			phase_step <= '0;
			win_lo <= '0;
			win_hi <= '0;
			fwd_re = 0;
			fwd_im = 0;
			expected_fields.delete();
			errors <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SOURCE_AMPLITUDE: src_amp <= cfg_data[30:0];
					REG_PHASE_STEP: phase_step <= cfg_data;
					REG_WINDOW_START: win_lo <= cfg_data;
					REG_WINDOW_STOP: win_hi <= cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) expected_fields.push_back(propagate_slice());
			if (out_valid && out_ready) begin
				got.re = field_real_out;
				got.im = field_imag_out;
				if (expected_fields.size() == 0) begin
					$error("unexpected result beat re=%0d im=%0d", got.re, got.im);
					errors <= errors + 1;
				end else begin
					want = expected_fields.pop_front();
					if (got.re !== want.re || got.im !== want.im) errors <= errors + 1;
					if (got.re !== want.re)
						$error("field_real_out: expected %0d, got %0d", want.re, got.re);
					if (got.im !== want.im)
						$error("field_imag_out: expected %0d, got %0d", want.im, got.im);
				end
			end
		end
	end

	assign pending = expected_fields.size();

endmodule

// ----- sim/tb_complex_field_slice_propagator_top.sv -----
`timescale 1ns / 1ps

module tb_complex_field_slice_propagator_top;
	import cfsp_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic                 first_slice;
	logic [31:0]          position;
	logic signed [15:0]   index_real;
	logic signed [15:0]   index_imag;
	logic signed [15:0]   trans_real;
	logic signed [15:0]   trans_imag;
	logic                 interface_here;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic signed [31:0]   field_real_out;
	logic signed [31:0]   field_imag_out;
	int                   pending;
	int                   errors;
	int                   idle_pct;
	int                   stall_pct;
	int                   cycles = 0;
	logic [31:0]          win_lo;
	logic [31:0]          win_hi;

	complex_field_slice_propagator_top dut (.*);

	field_slice_checker chk (.*);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(negedge clk)
		out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_regs(logic [31:0] amp, logic [31:0] ps, logic [31:0] lo,
			logic [31:0] hi);
		write_reg(REG_SOURCE_AMPLITUDE, amp);
		write_reg(REG_PHASE_STEP, ps);
		write_reg(REG_WINDOW_START, lo);
		write_reg(REG_WINDOW_STOP, hi);
		win_lo = lo;
		win_hi = hi;
	endtask

	task automatic send_slice(logic fs, logic [31:0] pos, logic [15:0] nr, logic [15:0] ni,
			logic [15:0] tr, logic [15:0] ti, logic ifc);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		first_slice <= fs;
		position <= pos;
		index_real <= nr;
		index_imag <= ni;
		trans_real <= tr;
		trans_imag <= ti;
		interface_here <= ifc;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// wait until every result is back, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	task automatic send_random();
		logic [31:0] pos;
		logic [15:0] nr, ni, tr, ti;
		case ($urandom_range(3))
			0: pos = $urandom;
			1: pos = win_lo + $urandom_range(2) - 1;
			2: pos = win_hi + $urandom_range(2) - 1;
			default: pos = win_lo + $urandom_range(1000);
		endcase
		nr = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(8192) - 1024);
		ni = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(64) - 32);
		if ($urandom_range(9) < 6) begin
			tr = 16'(16384 - $urandom_range(4000));
			ti = 16'($urandom_range(4000) - 2000);
		end else begin
			tr = 16'($urandom);
			ti = 16'($urandom);
		end
		send_slice($urandom_range(11) == 0, pos, nr, ni, tr, ti, $urandom_range(9) < 3);
	endtask

	task automatic random_regs();
		logic [31:0] amp, ps, lo;
		case ($urandom_range(2))
			0: amp = 32'h0100_0000;
			1: amp = $urandom;
			default: amp = $urandom_range(1 << 20);
		endcase
		ps = $urandom >> $urandom_range(31);
		lo = $urandom;
		if ($urandom_range(4) == 0) set_regs(amp, ps, lo, lo - $urandom_range(100));
		else set_regs(amp, ps, lo, lo + $urandom_range(2000) + 2);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		first_slice = 1'b0;
		position = '0;
		index_real = '0;
		index_imag = '0;
		trans_real = '0;
		trans_imag = '0;
		interface_here = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		win_lo = '0;
		win_hi = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// registers still at reset values: zero amplitude, empty window
		send_slice(1'b1, 32'hFFFF_FFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 1'b1);
		send_slice(1'b0, 32'd0, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b0);
		drain();

		// extremes; unknown registers and upper data bits are ignored
		write_reg(8'hFF, 32'hFFFF_FFFF);
		write_reg(8'd4, 32'h0);
		set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
		send_slice(1'b1, 32'd1, 16'h7FFF, 16'h0000, 16'h7FFF, 16'h7FFF, 1'b1);
		send_slice(1'b1, 32'hFFFF_FFFF, 16'h0000, 16'h8000, 16'h8000, 16'h8000, 1'b1);
		send_slice(1'b1, 32'd0, 16'h0000, 16'h7FFF, 16'h4000, 16'h0000, 1'b0);
		send_slice(1'b1, 32'd0, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 1'b1);
		send_slice(1'b0, 32'd5, 16'h8000, 16'h0000, 16'h7FFF, 16'h7FFF, 1'b1);
		drain();

		set_regs(32'h0100_0000, 32'h0010_0000, 32'd100, 32'd200);
		send_slice(1'b1, 32'd100, 16'h1000, 16'h0100, 16'h4000, 16'h0000, 1'b0);
		send_slice(1'b0, 32'd101, 16'h1000, 16'h0100, 16'h3000, 16'h1000, 1'b1);
		send_slice(1'b0, 32'd199, 16'hF000, 16'hFF00, 16'h4000, 16'hC000, 1'b1);
		send_slice(1'b0, 32'd200, 16'h2000, 16'h0040, 16'h7FFF, 16'h0000, 1'b1);
		send_slice(1'b0, 32'd150, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 1'b0);
		send_slice(1'b1, 32'h5555_5555, 16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF, 1'b0);
		send_slice(1'b0, 32'hAAAA_AAAA, 16'h7FFF, 16'hFFC0, 16'h4000, 16'h0000, 1'b0);
		drain();

		// empty window: start above stop
		set_regs(32'h7FFF_FFFF, 32'h0001_0000, 32'd300, 32'd299);
		send_slice(1'b1, 32'd299, 16'h0800, 16'hFFF0, 16'h4000, 16'h0000, 1'b0);
		send_slice(1'b0, 32'd300, 16'h0800, 16'hFFF0, 16'h4000, 16'h0000, 1'b0);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 63 : 33) : 0;
			stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 63 : 33) : 0;
			random_regs();
			for (int n = 0; n < 450; n++) begin
				send_random();
				if (n == 225 && ph != 0) begin
					drain();
					random_regs();
				end
				if (n % 150 == 75 && ph == 0) begin
					idle_pct = 0;
					drain();
				end
			end
			drain();
		end

		in_valid <= 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		while (pending != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (errors == 0 && pending == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/cfsp_pkg.sv
rtl/cfsp_ctrl.sv
rtl/cfsp_dp.sv
rtl/complex_field_slice_propagator_top.sv
sim/field_slice_checker.sv
sim/tb_complex_field_slice_propagator_top.sv
